// ===== rtl/bsed_pkg.sv =====
// Shared types, character codes and a hex digit helper for the backslash escape decoder.
`timescale 1ns / 1ps
package bsed_pkg;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_OCT    = 3'd4
  } mode_t;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_ESC    = 8'h1B;

  // APB register index
  localparam logic REG_ENABLE = 1'b0;

  // Results of one input word: up to three bytes, slot 0 goes out first
  typedef struct packed {
    logic [1:0]      cnt;
    logic            stop;
    logic [2:0][7:0] bytes;
  } res_t;

  // Hex digit value with a valid flag in the top bit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/bsed_decoder.sv =====
// Escape decode state and the single-pass logic that maps one word to its results.
`timescale 1ns / 1ps
module bsed_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          enable,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output bsed_pkg::res_t res
);
  import bsed_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [1:0] left_r, left_nxt;
  logic       stopped_r, stopped_nxt;

  logic [4:0] hx;
  logic       is_oct;
  logic [7:0] oct_acc;
  logic [1:0] left_dec;

  assign hx       = hex_val(in_byte);
  assign is_oct   = (in_byte inside {[8'h30:8'h37]});
  assign oct_acc  = {pend_r[4:0], 3'b000} + {5'd0, in_byte[2:0]};
  assign left_dec = left_r - 2'd1;

  // Decode one word against the current mode
  always_comb begin
    mode_nxt    = mode_r;
    pend_nxt    = pend_r;
    left_nxt    = left_r;
    stopped_nxt = stopped_r;
    res         = '0;

    if (!enable) begin
      res.bytes[0] = in_byte;
      res.cnt      = 2'd1;
      mode_nxt     = MODE_NORMAL;
      pend_nxt     = 8'd0;
      left_nxt     = 2'd0;
      stopped_nxt  = 1'b0;
    end else if (!stopped_r) begin
      case (mode_r)
        MODE_ESC: begin
          mode_nxt = MODE_NORMAL;
          res.cnt  = 2'd1;
          case (in_byte)
            8'h61: res.bytes[0] = 8'h07;
            8'h62: res.bytes[0] = 8'h08;
            8'h65: res.bytes[0] = CH_ESC;
            8'h66: res.bytes[0] = 8'h0C;
            8'h6E: res.bytes[0] = 8'h0A;
            8'h72: res.bytes[0] = 8'h0D;
            8'h74: res.bytes[0] = 8'h09;
            8'h76: res.bytes[0] = 8'h0B;
            CH_BSLASH: res.bytes[0] = CH_BSLASH;
            8'h63: begin
              res.stop    = 1'b1;
              stopped_nxt = !in_last;
            end
            CH_X: begin
              if (in_last) begin
                res.bytes[0] = CH_BSLASH;
                res.bytes[1] = CH_X;
                res.cnt      = 2'd2;
              end else begin
                res.cnt  = 2'd0;
                mode_nxt = MODE_HEX1;
              end
            end
            default: begin
              if (is_oct) begin
                pend_nxt     = {5'd0, in_byte[2:0]};
                left_nxt     = (in_byte == CH_0) ? 2'd3 : 2'd2;
                res.bytes[0] = {5'd0, in_byte[2:0]};
                if (!in_last) begin
                  res.cnt  = 2'd0;
                  mode_nxt = MODE_OCT;
                end
              end else begin
                res.bytes[0] = CH_BSLASH;
                res.bytes[1] = in_byte;
                res.cnt      = 2'd2;
              end
            end
          endcase
        end
        MODE_HEX1: begin
          if (hx[4]) begin
            pend_nxt     = {4'd0, hx[3:0]};
            res.bytes[0] = {4'd0, hx[3:0]};
            if (in_last) res.cnt = 2'd1;
            else mode_nxt = MODE_HEX2;
          end else begin
            res.bytes[0] = CH_BSLASH;
            res.bytes[1] = CH_X;
            res.bytes[2] = in_byte;
            mode_nxt     = MODE_NORMAL;
            if (in_byte == CH_BSLASH && !in_last) begin
              res.cnt  = 2'd2;
              mode_nxt = MODE_ESC;
            end else begin
              res.cnt = 2'd3;
            end
          end
        end
        MODE_HEX2: begin
          mode_nxt = MODE_NORMAL;
          if (hx[4]) begin
            res.bytes[0] = {pend_r[3:0], hx[3:0]};
            res.cnt      = 2'd1;
          end else begin
            res.bytes[0] = pend_r;
            res.bytes[1] = in_byte;
            if (in_byte == CH_BSLASH && !in_last) begin
              res.cnt  = 2'd1;
              mode_nxt = MODE_ESC;
            end else begin
              res.cnt = 2'd2;
            end
          end
        end
        MODE_OCT: begin
          if (is_oct && left_r != 2'd0) begin
            pend_nxt     = oct_acc;
            left_nxt     = left_dec;
            res.bytes[0] = oct_acc;
            if (left_dec == 2'd0 || in_last) begin
              res.cnt  = 2'd1;
              mode_nxt = MODE_NORMAL;
            end
          end else begin
            mode_nxt     = MODE_NORMAL;
            res.bytes[0] = pend_r;
            res.bytes[1] = in_byte;
            if (in_byte == CH_BSLASH && !in_last) begin
              res.cnt  = 2'd1;
              mode_nxt = MODE_ESC;
            end else begin
              res.cnt = 2'd2;
            end
          end
        end
        default: begin
          mode_nxt     = MODE_NORMAL;
          res.bytes[0] = in_byte;
          if (in_byte == CH_BSLASH && !in_last) mode_nxt = MODE_ESC;
          else res.cnt = 2'd1;
        end
      endcase
    end

    // End of string drops all escape state
    if (in_last) begin
      mode_nxt    = MODE_NORMAL;
      pend_nxt    = 8'd0;
      left_nxt    = 2'd0;
      stopped_nxt = 1'b0;
    end
  end

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      pend_r    <= 8'd0;
      left_r    <= 2'd0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      pend_r    <= pend_nxt;
      left_r    <= left_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ===== rtl/backslash_escape_decoder_unit.sv =====
// Top level of the backslash escape decoder: APB register, decoder and result buffer.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_byte, in_last    | in
//   result  | out_valid, out_stall, out_byte,         | out
//           | out_stop, out_run_last                  |
//   config  | psel, penable, pwrite, paddr, pwdata,   | APB
//           | prdata, pready                          |
//
// An accepted word's first result is in the result buffer in the following cycle.
// A word that gives one result sustains one word per cycle while out_stall is low;
// a word with two or three results holds the input while the buffer drains one
// result per cycle, as out_stall allows. Words that give no result load nothing.
// Reset (synchronous, active low) clears the decoder state, the buffer count
// and the enable register. A stall on the result side holds the buffer head.
`timescale 1ns / 1ps
module backslash_escape_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_stop,
  output logic        out_run_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsed_pkg::*;

  logic            enable_r;
  logic            in_acc;
  logic            out_acc;
  logic            load;
  res_t            res;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            stop_r, stop_nxt;
  logic [2:0][7:0] buf_r, buf_nxt;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, enable_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_ENABLE) begin
      enable_r <= pwdata[0];
    end
  end

  // Input handshake: take a word once the buffer is empty or sending its last
  assign in_stall = (cnt_r > 2'd1) || (cnt_r == 2'd1 && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign load     = in_acc && res.cnt != 2'd0;

  bsed_decoder u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .enable  (enable_r),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  // Load new results or shift the buffer down by one result
  always_comb begin
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    buf_nxt  = buf_r;
    if (load) begin
      cnt_nxt  = res.cnt;
      stop_nxt = res.stop;
      buf_nxt  = res.bytes;
    end else if (out_acc) begin
      cnt_nxt    = cnt_r - 2'd1;
      stop_nxt   = 1'b0;
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      stop_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_valid    = cnt_r != 2'd0;
  assign out_byte     = buf_r[0];
  assign out_stop     = stop_r;
  assign out_run_last = cnt_r == 2'd1;

  // A stop word is always the only result of its input word
  a_stop_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop |-> out_run_last)
    else $error("stop word not marked last");

  // A stop word carries a zero byte
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop |-> out_byte == 8'd0)
    else $error("stop word with nonzero byte");

  // With escapes off each word gives exactly one result
  a_pass_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !enable_r |=> cnt_r == 2'd1 && !stop_r)
    else $error("pass-through word did not give one result");

  // Buffer count steps down from three to two when a result leaves and nothing loads
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !load && cnt_r == 2'd3 |=> cnt_r == 2'd2)
    else $error("buffer count out of step");

endmodule
